// ===== hdl/ght_pkg.sv =====
// ---------------------------------------------------------------------------
// Generational handle table package
// Shared constants, payload words, codes and controller/datapath bundles.
// ---------------------------------------------------------------------------
package ght_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int UUID_W      = 64;
    localparam int GEN_W       = 32;
    localparam int MAX_W       = 9;

    localparam logic [GEN_W-1:0] GEN_UNINIT = '1;
    localparam logic [GEN_W-1:0] GEN_RESET  = GEN_W'(1);
    localparam logic [MAX_W-1:0] MAX_RESET  = MAX_W'(256);

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_LOOKUP  = 2'd1,
        FN_DESTROY = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_DELETED   = 3'd2,
        ST_DESTROYED = 3'd3,
        ST_FULL      = 3'd4,
        ST_UNINIT    = 3'd5
    } t_status;

    typedef struct packed {
        t_func             func;
        logic [UUID_W-1:0] handle_uuid;
        logic [7:0]        handle_index;
        logic [GEN_W-1:0]  handle_generation;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [7:0]        slot_index;
        logic [GEN_W-1:0]  out_generation;
        logic [UUID_W-1:0] out_uuid;
    } t_out;

    typedef struct packed {
        logic    load;
        logic    walk_init;
        logic    walk_from_slot;
        logic    walk;
        logic    shift_wr;
        logic    take_idx;
        logic    capture;
        logic    emit;
        logic    alloc;
        logic    destroy;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  gen_zero;
        logic  gen_ones;
        logic  gen_match;
        logic  idx_live;
        logic  hit;
        logic  dval;
        logic  walk_end;
        logic  out_free;
    } t_dp_sts;

endpackage

// ===== hdl/ght_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ght_dp.sv =====
// ---------------------------------------------------------------------------
// Generational handle table datapath
// Slot store, counters, walk pointer, handle checks and result register.
// ---------------------------------------------------------------------------
module ght_dp import ght_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in              i_in_data,
    input  logic             i_cfg_we,
    input  logic [MAX_W-1:0] i_cfg_wdata,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);

    t_in               r_in;
    logic [MAX_W-1:0]  r_max;
    logic [CNT_W-1:0]  r_count;
    logic [GEN_W-1:0]  r_tgen;
    logic [UUID_W-1:0] r_uctr;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_dptr;
    logic              r_dval;
    logic [ADDR_W-1:0] r_slot;
    t_out              r_out;
    logic              r_out_vld;

    logic [UUID_W-1:0] uctr_inc;
    logic [MAX_W-1:0]  limit;
    logic [CNT_W-1:0]  walk_base;
    logic              rd_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [UUID_W-1:0] ram_wdata;
    logic [UUID_W-1:0] ram_rdata;
    t_out              n_out;

    assign uctr_inc  = r_uctr + UUID_W'(1);
    assign limit     = (r_max < MAX_W'(TABLE_DEPTH)) ? r_max : MAX_W'(TABLE_DEPTH);
    assign walk_base = i_cmd.walk_from_slot ? (CNT_W'(r_slot) + CNT_W'(1)) : '0;
    assign rd_en     = (r_ptr < r_count);

    // During compaction the registered read word moves down one slot.
    assign ram_we    = i_cmd.alloc | (i_cmd.shift_wr & r_dval);
    assign ram_waddr = i_cmd.alloc ? r_count[ADDR_W-1:0]
                                   : (r_dptr[ADDR_W-1:0] - ADDR_W'(1));
    assign ram_wdata = i_cmd.alloc ? uctr_inc : ram_rdata;

    ght_ram #(
        .WIDTH (UUID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_out = '0;
        n_out.status = i_cmd.code;
        unique case (i_cmd.code)
            ST_OK, ST_REFRESHED: begin
                n_out.out_generation = r_tgen;
                if (i_cmd.alloc) begin
                    n_out.slot_index = 8'(r_count);
                    n_out.out_uuid   = uctr_inc;
                end else begin
                    n_out.slot_index = 8'(r_slot);
                    n_out.out_uuid   = r_in.handle_uuid;
                end
            end
            ST_DELETED, ST_DESTROYED, ST_UNINIT: begin
                n_out.out_uuid = r_in.handle_uuid;
            end
            ST_FULL: begin
                n_out.out_uuid = '0;
            end
            default: begin
                n_out.out_uuid = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.take_idx) begin
            r_slot <= ADDR_W'(r_in.handle_index);
        end else if (i_cmd.capture) begin
            r_slot <= r_dptr[ADDR_W-1:0];
        end
        if (i_cmd.walk) begin
            r_dptr <= r_ptr;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= MAX_RESET;
            r_count   <= '0;
            r_tgen    <= GEN_RESET;
            r_uctr    <= '0;
            r_ptr     <= '0;
            r_dval    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.walk_init) begin
                r_ptr  <= walk_base;
                r_dval <= 1'b0;
            end else if (i_cmd.walk) begin
                if (rd_en) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                r_dval <= rd_en;
            end
            if (i_cmd.alloc) begin
                r_count <= r_count + CNT_W'(1);
                r_uctr  <= uctr_inc;
            end else if (i_cmd.destroy) begin
                r_count <= r_count - CNT_W'(1);
                r_tgen  <= r_tgen + GEN_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.func      = r_in.func;
    assign o_sts.full      = ({{MAX_W{1'b0}}, r_count} >= {{CNT_W{1'b0}}, limit});
    assign o_sts.gen_zero  = (r_in.handle_generation == '0);
    assign o_sts.gen_ones  = (r_in.handle_generation == GEN_UNINIT);
    assign o_sts.gen_match = (r_in.handle_generation == r_tgen);
    assign o_sts.idx_live  = (CNT_W'(r_in.handle_index) < r_count);
    assign o_sts.hit       = r_dval && (ram_rdata == r_in.handle_uuid);
    assign o_sts.dval      = r_dval;
    assign o_sts.walk_end  = !rd_en;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/ght_ctrl.sv =====
// ---------------------------------------------------------------------------
// Generational handle table controller
// Sequences decode, unique-id search, compaction and result hand-off.
// ---------------------------------------------------------------------------
module ght_ctrl import ght_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_PREP,
        S_SHIFT,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.func == FN_NONE) begin
                    n_state = S_IDLE;
                end else if (i_sts.func == FN_ALLOC) begin
                    n_code  = i_sts.full ? ST_FULL : ST_OK;
                    n_state = S_EMIT;
                end else if (i_sts.gen_zero) begin
                    n_code  = ST_DESTROYED;
                    n_state = S_EMIT;
                end else if (i_sts.gen_ones) begin
                    n_code  = ST_UNINIT;
                    n_state = S_EMIT;
                end else if (i_sts.gen_match) begin
                    if (!i_sts.idx_live) begin
                        n_code  = ST_DELETED;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.take_idx = 1'b1;
                        n_code         = ST_OK;
                        n_state        = (i_sts.func == FN_DESTROY) ? S_PREP : S_EMIT;
                    end
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_code          = ST_REFRESHED;
                    n_state         = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // The read port is registered, so its data trails the pointer.
                o_cmd.walk = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = (i_sts.func == FN_DESTROY) ? S_PREP : S_EMIT;
                end else if (!i_sts.dval && i_sts.walk_end) begin
                    n_code  = ST_DELETED;
                    n_state = S_EMIT;
                end
            end
            S_PREP: begin
                o_cmd.walk_init      = 1'b1;
                o_cmd.walk_from_slot = 1'b1;
                n_state              = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.walk     = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (!i_sts.dval && i_sts.walk_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Table state changes in the same cycle the result word is loaded.
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.alloc   = (i_sts.func == FN_ALLOC) && (r_code == ST_OK);
                    o_cmd.destroy = (i_sts.func == FN_DESTROY)
                                    && ((r_code == ST_OK) || (r_code == ST_REFRESHED));
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

// ===== hdl/generational_handle_table_top.sv =====
// ---------------------------------------------------------------------------
// Generational handle table
// Dense table of unique ids with allocate, lookup and destroy operations.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Word
//  in        input      i_in_valid / o_in_ready    t_in  (func, handle fields)
//  out       output     o_out_valid / i_out_ready  t_out (status, slot, gen, uuid)
//  cfg       input      i_cfg_we                   i_cfg_wdata (max_entries)
//
//  One word is in work at a time. Allocate and rejected handles go from decode
//  straight to the result; a stale-generation handle first searches the live
//  slots, and a destroy compacts the slots above the removed one.
//  Search and compaction walk the slot RAM one slot per cycle on its read port.
//  Reset is synchronous: live count 0, generation 1, id counter 0, limit 256;
//  the slot RAM is not cleared. A stalled result holds in the output register
//  while the next word is accepted and worked on.
// ---------------------------------------------------------------------------
module generational_handle_table_top import ght_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic [MAX_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ght_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== hdl/ght_checker.sv =====
// ---------------------------------------------------------------------------
// Generational handle table checker
// Port-level properties of the handle table, bound to the top level.
// ---------------------------------------------------------------------------
module ght_checker import ght_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // Only one word is worked on at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on two consecutive cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result word changed or dropped");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_UNINIT))
        else $error("result status out of range");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL)) |->
        ((o_out_data.slot_index == '0) && (o_out_data.out_generation == '0)
         && (o_out_data.out_uuid == '0)))
        else $error("full result carries nonzero fields");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_data.status == ST_DELETED)
                         || (o_out_data.status == ST_DESTROYED)
                         || (o_out_data.status == ST_UNINIT))) |->
        ((o_out_data.slot_index == '0) && (o_out_data.out_generation == '0)))
        else $error("rejected handle result carries slot or generation");

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// Generational handle table testbench
// Drives allocate, lookup and destroy words into the table, predicts each
// reply from a private copy of the table, and checks the replies in order.
// The run covers a short directed part, then randomized phases under several
// entry limits. Both channels idle at random, the receiver holds off once for
// a long stretch, and the sender drains owed replies mid-run and per phase.
// ---------------------------------------------------------------------------
module tb;
    import ght_pkg::*;

    localparam int SETTLE = 300;        // longer than a full search or compaction
    localparam int HOLD   = 400;
    localparam int LIMIT  = 2_000_000;
    localparam int PHASES = 7;

    // Keeps the expected contents of the table and the replies still owed.
    class handle_book;
        logic [UUID_W-1:0] ids [TABLE_DEPTH];
        int                live;
        logic [GEN_W-1:0]  gen;
        logic [UUID_W-1:0] last_id;
        logic [MAX_W-1:0]  cap;
        t_out              replies_due [$];
        int                errors;

        function new();
            live    = 0;
            gen     = GEN_RESET;
            last_id = '0;
            cap     = MAX_RESET;
            errors  = 0;
        endfunction

        function void set_cap(logic [MAX_W-1:0] v);
            cap = v;
        endfunction

        // Works out the reply to an accepted word and updates the table.
        function void take_request(t_in w);
            t_out    r;
            t_status st;
            int      limit;
            int      slot;
            int      i;
            r     = '0;
            slot  = 0;
            limit = (cap < TABLE_DEPTH) ? cap : TABLE_DEPTH;
            if (w.func == FN_NONE) return;
            if (w.func == FN_ALLOC) begin
                if (live >= limit) begin
                    r.status = ST_FULL;
                end else begin
                    last_id    = last_id + 1;
                    ids[live]  = last_id;
                    r.status   = ST_OK;
                    r.slot_index     = 8'(live);
                    r.out_generation = gen;
                    r.out_uuid       = last_id;
                    live++;
                end
                replies_due.push_back(r);
                return;
            end
            if (w.handle_generation == '0) begin
                st = ST_DESTROYED;
            end else if (w.handle_generation == GEN_UNINIT) begin
                st = ST_UNINIT;
            end else if (w.handle_generation == gen) begin
                if (w.handle_index >= live) begin
                    st = ST_DELETED;
                end else begin
                    st   = ST_OK;
                    slot = w.handle_index;
                end
            end else begin
                st = ST_DELETED;
                for (i = 0; i < live; i++) begin
                    if (ids[i] == w.handle_uuid) begin
                        st   = ST_REFRESHED;
                        slot = i;
                        break;
                    end
                end
            end
            r.status   = st;
            r.out_uuid = w.handle_uuid;
            if (st == ST_OK || st == ST_REFRESHED) begin
                r.slot_index     = 8'(slot);
                r.out_generation = gen;
                if (w.func == FN_DESTROY) begin
                    for (i = slot; i + 1 < live; i++) ids[i] = ids[i + 1];
                    live--;
                    gen = gen + 1;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(t_out got);
            t_out want;
            if (replies_due.size() == 0) begin
                $display("%0t: reply with nothing pending, got %h", $time, got);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status,
                         got.status);
                errors++;
            end
            if (got.slot_index !== want.slot_index) begin
                $display("%0t: slot_index expected %0d, got %0d", $time,
                         want.slot_index, got.slot_index);
                errors++;
            end
            if (got.out_generation !== want.out_generation) begin
                $display("%0t: out_generation expected %h, got %h", $time,
                         want.out_generation, got.out_generation);
                errors++;
            end
            if (got.out_uuid !== want.out_uuid) begin
                $display("%0t: out_uuid expected %h, got %h", $time, want.out_uuid,
                         got.out_uuid);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic [MAX_W-1:0] i_cfg_wdata;

    handle_book sb;
    bit         steady   = 1'b0;
    bit         hold_req = 1'b0;
    int         cycles   = 0;

    generational_handle_table_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[generational_handle_table_top] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_reply(o_out_data);
    end

    // Receiver: short random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in req(t_func f, logic [UUID_W-1:0] u, logic [7:0] i,
                                logic [GEN_W-1:0] g);
        t_in w;
        w.func              = f;
        w.handle_uuid       = u;
        w.handle_index      = i;
        w.handle_generation = g;
        return w;
    endfunction

    // A generation that differs from the table's and is neither reserved value.
    function automatic logic [GEN_W-1:0] stale_gen();
        logic [GEN_W-1:0] g;
        g = $urandom_range(0, 1) ? sb.gen - 1 : GEN_W'($urandom);
        while (g == sb.gen || g == '0 || g == GEN_UNINIT) g = $urandom;
        return g;
    endfunction

    // Mostly handles taken from the live table, with dead ids, reserved
    // generations and raw noise mixed in.
    function automatic t_in make_request(int alloc_pct);
        t_in w;
        int  r;
        int  s;
        w.func              = FN_ALLOC;
        w.handle_uuid       = {$urandom, $urandom};
        w.handle_index      = 8'($urandom);
        w.handle_generation = $urandom;
        if ($urandom_range(0, 99) < alloc_pct) return w;
        r = $urandom_range(0, 99);
        w.func = $urandom_range(0, 1) ? FN_LOOKUP : FN_DESTROY;
        if (r < 2) begin
            w.func = FN_NONE;
        end else if (r < 8) begin
            w.func = t_func'($urandom_range(0, 3));
        end else if (r < 12) begin
            w.handle_generation = '0;
        end else if (r < 16) begin
            w.handle_generation = GEN_UNINIT;
        end else if (r < 30 || sb.live == 0) begin
            if ($urandom_range(0, 1)) w.handle_uuid = sb.last_id - $urandom_range(0, 20);
            w.handle_generation = stale_gen();
        end else begin
            s = $urandom_range(0, sb.live - 1);
            w.handle_uuid = sb.ids[s];
            if (r < 65) begin
                w.handle_index      = 8'(s);
                w.handle_generation = sb.gen;
            end else if (r < 70) begin
                w.handle_generation = sb.gen;
            end else begin
                w.handle_generation = stale_gen();
            end
        end
        return w;
    endfunction

    task automatic send(input t_in w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_request(w);
    endtask

    // The limit only changes with the table idle, so wait out any work left.
    task automatic set_limit(input logic [MAX_W-1:0] v);
        i_in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_cap(v);
    endtask

    initial begin
        int               p;
        int               n;
        logic [MAX_W-1:0] caps   [PHASES];
        int               counts [PHASES];
        int               allocs [PHASES];
        caps   = '{9'd511, 9'd0, 9'd2, 9'd5, 9'd256, 9'd40, 9'd300};
        counts = '{250, 30, 100, 120, 300, 150, 150};
        allocs = '{60, 20, 40, 40, 75, 40, 40};
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reserved generations and stale indexes on an empty table, then allocates.
        send(req(FN_LOOKUP, 64'd5, 8'd0, 32'd0));
        send(req(FN_LOOKUP, '1, 8'd255, GEN_UNINIT));
        send(req(FN_DESTROY, 64'd7, 8'd3, 32'd0));
        send(req(FN_DESTROY, 64'd7, 8'd3, GEN_UNINIT));
        send(req(FN_LOOKUP, 64'd0, 8'd0, 32'd1));
        send(req(FN_DESTROY, 64'd0, 8'd0, 32'd1));
        send(req(FN_ALLOC, '1, 8'd255, GEN_UNINIT));
        send(req(FN_ALLOC, '0, 8'd0, 32'd0));
        send(req(FN_ALLOC, 64'd1, 8'd1, 32'd1));
        send(req(FN_ALLOC, 64'd9, 8'd7, 32'd3));
        // Current handles, an index past the live count, then stale handles.
        send(req(FN_LOOKUP, 64'd2, 8'd1, 32'd1));
        send(req(FN_LOOKUP, 64'd9, 8'd255, 32'd1));
        send(req(FN_LOOKUP, 64'd3, 8'd0, 32'h1234));
        send(req(FN_LOOKUP, '1, 8'd0, 32'h8000_0000));
        send(req(FN_DESTROY, 64'd1, 8'd0, 32'd1));
        send(req(FN_LOOKUP, 64'd4, 8'd3, 32'd1));
        send(req(FN_DESTROY, 64'd4, 8'd3, 32'd1));
        send(req(FN_DESTROY, 64'd1, 8'd0, 32'd1));
        send(req(FN_NONE, '1, 8'd255, 32'd3));
        send(req(FN_LOOKUP, 64'd2, 8'd0, 32'd3));
        send(req(FN_LOOKUP, 64'd2, 8'd0, 32'hFFFF_FFFE));
        send(req(FN_DESTROY, 64'd2, 8'd2, 32'd3));
        send(req(FN_ALLOC, '1, 8'd0, 32'd0));

        for (p = 0; p < PHASES; p++) begin
            set_limit(caps[p]);
            steady = (p == PHASES - 1);
            for (n = 0; n < counts[p]; n++) begin
                if (p == 0 && n == 100) hold_req = 1'b1;
                if (p == 4 && n == 150) begin
                    i_in_valid <= 1'b0;
                    while (sb.replies_due.size() != 0) @(posedge i_clk);
                end else if (!steady && $urandom_range(0, 5) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
                send(make_request(allocs[p]));
            end
        end

        i_in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[generational_handle_table_top] OK");
        else
            $display("[generational_handle_table_top] ERROR");
        $finish;
    end
endmodule

// ===== generational_handle_table_top.f =====
hdl/ght_pkg.sv
hdl/ght_ram.sv
hdl/ght_dp.sv
hdl/ght_ctrl.sv
hdl/generational_handle_table_top.sv
hdl/ght_checker.sv
bench/tb.sv
